FILE: design/ssd_pkg.sv
`default_nettype none

package ssd_pkg;

    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int WORD_W           = 32;
    localparam int CNT_W            = 20;
    localparam int Q_DEPTH          = 2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_LOAD_LAST,
        OP_UNLOAD
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [WORD_W-1:0] value;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UNLOAD,
        S_FWD_INIT,
        S_FWD_CARRY,
        S_FWD_CMP,
        S_FWD_END,
        S_BWD_INIT,
        S_BWD_CARRY,
        S_BWD_CMP,
        S_BWD_END,
        S_DONE
    } t_state;

    localparam logic RSP_ELEMENT = 1'b0;
    localparam logic RSP_SUMMARY = 1'b1;

endpackage

`default_nettype wire

FILE: design/ssd_req_if.sv
`default_nettype none

interface ssd_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [31:0] value;
    logic               is_last_in;

    modport source (output valid, output req_type, output value, output is_last_in,
                    input ready);
    modport sink   (input valid, input req_type, input value, input is_last_in,
                    output ready);
endinterface

`default_nettype wire

FILE: design/ssd_rsp_if.sv
`default_nettype none

interface ssd_rsp_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [31:0] element;
    logic               is_last_out;
    logic [19:0]        comparisons;
    logic [19:0]        swaps;

    modport source (output valid, output kind, output element, output is_last_out,
                    output comparisons, output swaps, input ready);
    modport sink   (input valid, input kind, input element, input is_last_out,
                    input comparisons, input swaps, output ready);
endinterface

`default_nettype wire

FILE: design/shaker_sort_descending.sv
// Descending cocktail shaker sort.
// i_req carries beats of req_type/value/is_last_in; o_rsp carries beats of
// kind/element/is_last_out/comparisons/swaps. Both are valid/ready channels.
// A two-entry command queue takes request beats; the sorter drains it.
// Load beats: one per cycle while the sorter is idle, no response. A load marked
// last starts the sort, one comparison per cycle in its compare states, through
// the single-write, single-read word store with registered read. The summary
// beat appears once the sort ends and the output register is free.
// Unload beats: one response each via S_UNLOAD and the output register, the next
// only back in S_IDLE; an unload before a sort or past the word count gives none.
// Reset (i_rst_n low, synchronous) empties the queue, clears counts, pointer and
// sorted state and drops any pending response; store contents stay undefined.
// When o_rsp stalls, the output register holds the response; plain loads flow on,
// but an unload or last load waits at the head; a full queue drops i_req.ready.
`default_nettype none

module shaker_sort_descending import ssd_pkg::*; #(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ssd_req_if.sink   i_req,
    ssd_rsp_if.source o_rsp
);

    logic s_cmd_valid;
    t_cmd s_cmd;
    logic s_cmd_pop;

    ssd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (s_cmd_valid),
        .o_cmd       (s_cmd),
        .i_cmd_pop   (s_cmd_pop)
    );

    ssd_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (s_cmd_valid),
        .i_cmd       (s_cmd),
        .o_cmd_pop   (s_cmd_pop),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

FILE: design/ssd_front.sv
`default_nettype none

module ssd_front import ssd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ssd_req_if.sink   i_req,
    output logic      o_cmd_valid,
    output t_cmd      o_cmd,
    input  wire logic i_cmd_pop
);

    localparam int PTR_W  = $clog2(Q_DEPTH);
    localparam int FILL_W = $clog2(Q_DEPTH + 1);

    t_cmd              r_q [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [FILL_W-1:0] r_fill;
    t_cmd              s_cmd;
    logic              s_push;
    logic              s_pop;

    always_comb begin
        if (i_req.req_type) begin
            s_cmd.op = OP_UNLOAD;
        end else if (i_req.is_last_in) begin
            s_cmd.op = OP_LOAD_LAST;
        end else begin
            s_cmd.op = OP_LOAD;
        end
        s_cmd.value = i_req.value;
    end

    assign i_req.ready = (r_fill != FILL_W'(Q_DEPTH));
    assign s_push      = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_fill != '0);
    assign s_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_q[r_wr] <= s_cmd;
        end
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (s_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (s_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (s_push && !s_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (s_pop && !s_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/ssd_back.sv
`default_nettype none

module ssd_back import ssd_pkg::*; #(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    ssd_rsp_if.source o_rsp
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    logic [WORD_W-1:0] r_mem [MAX_ELEMENTS];
    logic [WORD_W-1:0] r_rdata;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_uptr, n_uptr;
    logic              r_sorted, n_sorted;
    logic [CNT_W-1:0]  r_cmp, n_cmp;
    logic [CNT_W-1:0]  r_swp, n_swp;
    logic [CW-1:0]     r_lo, n_lo;
    logic [CW-1:0]     r_idx, n_idx;
    logic [WORD_W-1:0] r_carry, n_carry;
    logic              r_again, n_again;

    logic              r_ovalid, n_ovalid;
    logic              r_okind, n_okind;
    logic [WORD_W-1:0] r_oelem, n_oelem;
    logic              r_olast, n_olast;
    logic [CNT_W-1:0]  r_ocmp, n_ocmp;
    logic [CNT_W-1:0]  r_oswp, n_oswp;

    logic              s_we;
    logic [AW-1:0]     s_waddr;
    logic [WORD_W-1:0] s_wdata;
    logic [AW-1:0]     s_raddr;

    logic              s_out_free;
    logic              s_pop;
    logic              s_is_load;
    logic              s_unload_ok;
    logic [CW-1:0]     s_eff;
    logic [CW-1:0]     s_eff_p1;
    logic              s_room;
    logic [CW-1:0]     s_hi;
    logic [CW-1:0]     s_idx_p1;
    logic [CW-1:0]     s_idx_m1;
    logic [CW-1:0]     s_idx_m2;
    logic [CW-1:0]     s_lo_p1;
    logic [CW-1:0]     s_uptr_p1;
    logic              s_fwd_empty;
    logic              s_fwd_gt;
    logic              s_bwd_gt;
    logic [CNT_W-1:0]  s_cmp_inc;
    logic [CNT_W-1:0]  s_swp_inc;

    assign s_out_free  = !r_ovalid || o_rsp.ready;
    assign s_is_load   = (i_cmd.op != OP_UNLOAD);
    assign s_pop       = (r_state == S_IDLE) && i_cmd_valid
                         && ((i_cmd.op == OP_LOAD) || s_out_free);
    assign o_cmd_pop   = s_pop;
    assign s_unload_ok = r_sorted && (r_uptr < r_count);
    assign s_eff       = r_sorted ? '0 : r_count;
    assign s_eff_p1    = s_eff + 1'b1;
    assign s_room      = (s_eff < CW'(MAX_ELEMENTS));
    assign s_hi        = r_count - r_lo - 1'b1;
    assign s_idx_p1    = r_idx + 1'b1;
    assign s_idx_m1    = r_idx - 1'b1;
    assign s_idx_m2    = r_idx - 2'd2;
    assign s_lo_p1     = r_lo + 1'b1;
    assign s_uptr_p1   = r_uptr + 1'b1;
    assign s_fwd_empty = ({1'b0, r_lo, 1'b1} >= {2'b00, r_count});
    assign s_fwd_gt    = $signed(r_rdata) > $signed(r_carry);
    assign s_bwd_gt    = $signed(r_carry) > $signed(r_rdata);
    assign s_cmp_inc   = (r_cmp == '1) ? r_cmp : r_cmp + 1'b1;
    assign s_swp_inc   = (r_swp == '1) ? r_swp : r_swp + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_pop) begin
                    if (i_cmd.op == OP_LOAD_LAST) begin
                        n_state = S_FWD_INIT;
                    end else if (!s_is_load && s_unload_ok) begin
                        n_state = S_UNLOAD;
                    end
                end
            end
            S_UNLOAD:    n_state = S_IDLE;
            S_FWD_INIT:  n_state = s_fwd_empty ? S_DONE : S_FWD_CARRY;
            S_FWD_CARRY: n_state = S_FWD_CMP;
            S_FWD_CMP:   n_state = (r_idx == s_hi) ? S_FWD_END : S_FWD_CMP;
            S_FWD_END:   n_state = r_again ? S_BWD_INIT : S_DONE;
            S_BWD_INIT:  n_state = S_BWD_CARRY;
            S_BWD_CARRY: n_state = S_BWD_CMP;
            S_BWD_CMP:   n_state = (r_idx == s_lo_p1) ? S_BWD_END : S_BWD_CMP;
            S_BWD_END:   n_state = S_FWD_INIT;
            S_DONE:      n_state = s_out_free ? S_IDLE : S_DONE;
            default:     n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_count  = r_count;
        n_uptr   = r_uptr;
        n_sorted = r_sorted;
        n_cmp    = r_cmp;
        n_swp    = r_swp;
        n_lo     = r_lo;
        n_idx    = r_idx;
        n_carry  = r_carry;
        n_again  = r_again;
        n_ovalid = r_ovalid && !o_rsp.ready;
        n_okind  = r_okind;
        n_oelem  = r_oelem;
        n_olast  = r_olast;
        n_ocmp   = r_ocmp;
        n_oswp   = r_oswp;
        s_we     = 1'b0;
        s_waddr  = '0;
        s_wdata  = i_cmd.value;
        s_raddr  = '0;
        case (r_state)
            S_IDLE: begin
                if (s_pop && s_is_load) begin
                    if (r_sorted) begin
                        n_sorted = 1'b0;
                        n_uptr   = '0;
                    end
                    n_count = s_eff;
                    if (s_room) begin
                        s_we    = 1'b1;
                        s_waddr = s_eff[AW-1:0];
                        n_count = s_eff_p1;
                    end
                    if (i_cmd.op == OP_LOAD_LAST) begin
                        n_lo  = '0;
                        n_cmp = '0;
                        n_swp = '0;
                    end
                end else if (s_pop && s_unload_ok) begin
                    s_raddr = r_uptr[AW-1:0];
                end
            end
            S_UNLOAD: begin
                n_ovalid = 1'b1;
                n_okind  = RSP_ELEMENT;
                n_oelem  = r_rdata;
                n_olast  = (s_uptr_p1 == r_count);
                n_ocmp   = '0;
                n_oswp   = '0;
                n_uptr   = s_uptr_p1;
            end
            S_FWD_INIT: begin
                s_raddr = r_lo[AW-1:0];
                n_idx   = s_lo_p1;
                n_again = 1'b0;
            end
            S_FWD_CARRY: begin
                n_carry = r_rdata;
                s_raddr = r_idx[AW-1:0];
            end
            S_FWD_CMP: begin
                // carry holds the word now at idx-1
                s_we    = 1'b1;
                s_waddr = s_idx_m1[AW-1:0];
                s_wdata = s_fwd_gt ? r_rdata : r_carry;
                n_carry = s_fwd_gt ? r_carry : r_rdata;
                n_cmp   = s_cmp_inc;
                if (s_fwd_gt) begin
                    n_swp   = s_swp_inc;
                    n_again = 1'b1;
                end
                if (r_idx != s_hi) begin
                    n_idx   = s_idx_p1;
                    s_raddr = s_idx_p1[AW-1:0];
                end
            end
            S_FWD_END: begin
                s_we    = 1'b1;
                s_waddr = s_hi[AW-1:0];
                s_wdata = r_carry;
            end
            S_BWD_INIT: begin
                s_raddr = s_hi[AW-1:0];
                n_idx   = s_hi;
            end
            S_BWD_CARRY: begin
                n_carry = r_rdata;
                s_raddr = s_idx_m1[AW-1:0];
            end
            S_BWD_CMP: begin
                // carry holds the word now at idx
                s_we    = 1'b1;
                s_waddr = r_idx[AW-1:0];
                s_wdata = s_bwd_gt ? r_rdata : r_carry;
                n_carry = s_bwd_gt ? r_carry : r_rdata;
                n_cmp   = s_cmp_inc;
                if (s_bwd_gt) begin
                    n_swp = s_swp_inc;
                end
                if (r_idx != s_lo_p1) begin
                    n_idx   = s_idx_m1;
                    s_raddr = s_idx_m2[AW-1:0];
                end
            end
            S_BWD_END: begin
                s_we    = 1'b1;
                s_waddr = r_lo[AW-1:0];
                s_wdata = r_carry;
                n_lo    = s_lo_p1;
            end
            S_DONE: begin
                if (s_out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = RSP_SUMMARY;
                    n_oelem  = '0;
                    n_olast  = 1'b0;
                    n_ocmp   = r_cmp;
                    n_oswp   = r_swp;
                    n_sorted = 1'b1;
                    n_uptr   = '0;
                end
            end
            default: begin
                n_ovalid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_mem[s_waddr] <= s_wdata;
        end
        r_rdata <= r_mem[s_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_idx   <= n_idx;
        r_carry <= n_carry;
        r_okind <= n_okind;
        r_oelem <= n_oelem;
        r_olast <= n_olast;
        r_ocmp  <= n_ocmp;
        r_oswp  <= n_oswp;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_uptr   <= '0;
            r_sorted <= 1'b0;
            r_cmp    <= '0;
            r_swp    <= '0;
            r_again  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_uptr   <= n_uptr;
            r_sorted <= n_sorted;
            r_cmp    <= n_cmp;
            r_swp    <= n_swp;
            r_again  <= n_again;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.kind        = r_okind;
    assign o_rsp.element     = $signed(r_oelem);
    assign o_rsp.is_last_out = r_olast;
    assign o_rsp.comparisons = r_ocmp;
    assign o_rsp.swaps       = r_oswp;

endmodule

`default_nettype wire

FILE: tb/ssd_tb_pkg.sv
`timescale 1ns / 100ps

package ssd_tb_pkg;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_UNLOAD = 1'b1;

endpackage

FILE: tb/shaker_sort_descending_checker.sv
`timescale 1ns / 100ps

module shaker_sort_descending_checker import ssd_pkg::*; import ssd_tb_pkg::*; #(
    parameter int MAX_ELEMS = DEF_MAX_ELEMENTS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ssd_req_if        i_req,
    ssd_rsp_if        i_rsp,
    output int        o_errors,
    output int        o_pending
);

    typedef struct packed {
        logic                     kind;
        logic signed [WORD_W-1:0] element;
        logic                     is_last;
        logic [CNT_W-1:0]         comparisons;
        logic [CNT_W-1:0]         swaps;
    } t_result;

    logic signed [WORD_W-1:0] words [MAX_ELEMS];
    int                       word_count;
    int                       next_out;
    bit                       batch_sorted;
    logic [CNT_W-1:0]         cmp_count;
    logic [CNT_W-1:0]         swp_count;
    t_result                  expected_q [$];
    t_result                  want;
    t_result                  got;
    int                       error_count = 0;
    int                       pending_count = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    function automatic void exchange_words(input int p, input int q);
        logic signed [WORD_W-1:0] t;
        t        = words[p];
        words[p] = words[q];
        words[q] = t;
        swp_count = sat_inc(swp_count);
    endfunction

    function automatic void shaker_descending();
        int n;
        int lo;
        bit moved;
        n         = word_count;
        lo        = 0;
        moved     = 1'b1;
        cmp_count = '0;
        swp_count = '0;
        while (moved) begin
            moved = 1'b0;
            for (int a = lo + 1; a + lo < n; a++) begin
                cmp_count = sat_inc(cmp_count);
                if (words[a] > words[a-1]) begin
                    exchange_words(a, a - 1);
                    moved = 1'b1;
                end
            end
            if (!moved)
                break;
            for (int b = n - lo - 1; b > lo; b--) begin
                cmp_count = sat_inc(cmp_count);
                if (words[b] > words[b-1])
                    exchange_words(b - 1, b);
            end
            lo++;
        end
        batch_sorted = 1'b1;
        next_out     = 0;
    endfunction

    function automatic void check_field(input string what, input logic [WORD_W-1:0] exp_v,
                                        input logic [WORD_W-1:0] act_v);
        if (exp_v !== act_v) begin
            error_count++;
            $display("%0t: %s expected %0h got %0h", $time, what, exp_v, act_v);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            word_count   = 0;
            next_out     = 0;
            batch_sorted = 1'b0;
            cmp_count    = '0;
            swp_count    = '0;
            expected_q.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.kind        = i_rsp.kind;
                got.element     = i_rsp.element;
                got.is_last     = i_rsp.is_last_out;
                got.comparisons = i_rsp.comparisons;
                got.swaps       = i_rsp.swaps;
                if (expected_q.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected beat, expected none got %0h", $time, got);
                end else begin
                    want = expected_q.pop_front();
                    check_field("kind", WORD_W'(want.kind), WORD_W'(got.kind));
                    check_field("element", want.element, got.element);
                    check_field("is_last_out", WORD_W'(want.is_last), WORD_W'(got.is_last));
                    check_field("comparisons", WORD_W'(want.comparisons),
                                WORD_W'(got.comparisons));
                    check_field("swaps", WORD_W'(want.swaps), WORD_W'(got.swaps));
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.req_type == REQ_LOAD) begin
                    if (batch_sorted) begin
                        batch_sorted = 1'b0;
                        word_count   = 0;
                        next_out     = 0;
                    end
                    if (word_count < MAX_ELEMS) begin
                        words[word_count] = i_req.value;
                        word_count++;
                    end
                    if (i_req.is_last_in) begin
                        shaker_descending();
                        want.kind        = RSP_SUMMARY;
                        want.element     = '0;
                        want.is_last     = 1'b0;
                        want.comparisons = cmp_count;
                        want.swaps       = swp_count;
                        expected_q.push_back(want);
                    end
                end else if (batch_sorted && next_out < word_count) begin
                    want.kind        = RSP_ELEMENT;
                    want.element     = words[next_out];
                    want.is_last     = (next_out + 1 == word_count);
                    want.comparisons = '0;
                    want.swaps       = '0;
                    expected_q.push_back(want);
                    next_out++;
                end
            end
        end
        pending_count = expected_q.size();
    end

endmodule

FILE: tb/shaker_sort_descending_tb.sv
`timescale 1ns / 100ps

module shaker_sort_descending_tb;
    import ssd_pkg::*;
    import ssd_tb_pkg::*;

    localparam int MAX_ELEMS    = DEF_MAX_ELEMENTS;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int ITEM_TARGET  = 340;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 64;

    typedef logic signed [WORD_W-1:0] t_word_q [$];

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    bit   quiet = 1'b0;
    int   hold_asked = 0;
    int   hold_done = 0;
    int   cycle_count = 0;
    int   items_sent = 0;

    ssd_req_if req_bus ();
    ssd_rsp_if rsp_bus ();

    shaker_sort_descending #(.MAX_ELEMENTS(MAX_ELEMS)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    shaker_sort_descending_checker #(.MAX_ELEMS(MAX_ELEMS)) sort_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_bus),
        .i_rsp     (rsp_bus),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // receiver: random stalls, or a long hold-off when asked
    initial begin
        forever begin
            if (hold_done != hold_asked) begin
                repeat (HOLD_CYCLES) begin
                    rsp_bus.ready <= 1'b0;
                    @(posedge i_clk);
                end
                hold_done++;
            end else begin
                rsp_bus.ready <= quiet || ($urandom_range(0, 99) >= 36);
                @(posedge i_clk);
            end
        end
    end

    task automatic send_beat(input logic rt, input logic signed [WORD_W-1:0] v,
                             input logic lst);
        while (!quiet && $urandom_range(0, 99) < 36) begin
            req_bus.valid <= 1'b0;
            req_bus.value <= $urandom();
            @(posedge i_clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= rt;
        req_bus.value      <= v;
        req_bus.is_last_in <= lst;
        @(posedge i_clk);
        while (!req_bus.ready)
            @(posedge i_clk);
    endtask

    task automatic load_word(input logic signed [WORD_W-1:0] v, input logic lst);
        send_beat(REQ_LOAD, v, lst);
    endtask

    // is_last_in and value are don't-care on an unload
    task automatic unload_word();
        send_beat(REQ_UNLOAD, $urandom(), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_batch(input t_word_q batch_words, input int unload_n);
        for (int i = 0; i < batch_words.size(); i++) begin
            if (i > 0 && $urandom_range(0, 19) == 0)
                unload_word();
            load_word(batch_words[i], i == batch_words.size() - 1);
            items_sent++;
        end
        for (int i = 0; i < unload_n; i++) begin
            unload_word();
            if (i < batch_words.size())
                items_sent++;
        end
    endtask

    function automatic logic signed [WORD_W-1:0] rand_word(input int style);
        int pick;
        pick = (style == 3) ? $urandom_range(0, 2) : style;
        case (pick)
            1: return int'($urandom_range(0, 8)) - 4;
            2: begin
                case ($urandom_range(0, 4))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000000;
                    2: return -1;
                    3: return 0;
                    default: return 1;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    initial begin
        t_word_q                  batch;
        int                       size;
        int                       style;
        int                       shape;
        int                       unload_n;
        int                       batch_idx;
        int                       pick;

        i_rst_n            <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.req_type   <= REQ_LOAD;
        req_bus.value      <= '0;
        req_bus.is_last_in <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unload with no sort yet, last flag set on an unload
        send_beat(REQ_UNLOAD, 32'sh5a5a5a5a, 1'b1);
        // single-word batch, then unload past the end
        run_batch('{32'sd0}, 2);
        // extremes and duplicates, unload before the sort, receiver hold-off
        load_word(32'sh80000000, 1'b0);
        load_word(32'sh7fffffff, 1'b0);
        unload_word();
        load_word(-1, 1'b0);
        load_word(0, 1'b0);
        load_word(1, 1'b0);
        load_word(32'sh7fffffff, 1'b0);
        load_word(32'sh80000000, 1'b1);
        hold_asked++;
        repeat (8) unload_word();

        batch_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            quiet = (batch_idx >= 6 && batch_idx < 10);
            pick  = $urandom_range(0, 99);
            size  = (pick < 70) ? $urandom_range(1, 8) :
                    (pick < 95) ? $urandom_range(9, 32) : $urandom_range(33, 64);
            style = $urandom_range(0, 3);
            batch.delete();
            repeat (size) batch.push_back(rand_word(style));
            shape = $urandom_range(0, 9);
            if (shape < 2)
                batch.sort();
            else if (shape == 2)
                batch.rsort();
            unload_n = ($urandom_range(0, 99) < 80) ? size + $urandom_range(0, 2)
                                                     : $urandom_range(0, size);
            if ($urandom_range(0, 19) == 0)
                hold_asked++;
            run_batch(batch, unload_n);
            batch_idx++;
        end
        quiet = 1'b0;

        // larger ascending batch: worst case for a descending sort
        batch.delete();
        repeat (64) batch.push_back($urandom());
        batch.sort();
        run_batch(batch, 64);

        batch.delete();
        repeat (3) batch.push_back(rand_word(3));
        run_batch(batch, 3);

        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
